/* src/rsb_pkg.sv */
// Package: shared types, codes and helpers for the retry scheduler with backoff.
`timescale 1ns / 1ps
package rsb_pkg;

   localparam int TIME_W      = 32;
   localparam int CNT_W       = 16;
   localparam int JOB_W       = 6;
   localparam int PEND_W      = 7;
   localparam int STATUS_W    = 3;
   localparam int CSR_IDX_W   = 3;
   localparam int NUM_SVC     = 2;
   localparam int MASK_W      = NUM_SVC;
   localparam int DEF_MAX_JOBS = 64;

   localparam logic [TIME_W-1:0] FIRST_BACKOFF_MS = TIME_W'(1000);
   localparam logic [TIME_W-1:0] DEF_MAX_BACKOFF  = TIME_W'(60000);
   localparam logic [CNT_W-1:0]  CNT_MAX          = '1;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_ADD    = 2'd1,
      OP_PICK   = 2'd2,
      OP_REPORT = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      OUTC_SUCCESS   = 2'd0,
      OUTC_TRANSIENT = 2'd1,
      OUTC_HARD      = 2'd2
   } outcome_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE      = 3'd0,
      ST_NONE_DUE  = 3'd1,
      ST_SKIPPED   = 3'd2,
      ST_FULL      = 3'd3,
      ST_NOT_OWED  = 3'd4
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SERVICES   = 3'd0,
      CSR_SVC0_MIN   = 3'd1,
      CSR_SVC0_MAXBO = 3'd2,
      CSR_SVC1_MIN   = 3'd3,
      CSR_SVC1_MAXBO = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DUE0,
      S_DUE1,
      S_SCAN,
      S_RPT_RD,
      S_RPT_CHK,
      S_CAP,
      S_NEXT,
      S_OUT
   } state_type;

   typedef struct packed {
      logic [1:0]        op;
      logic [TIME_W-1:0] now_ms;
      logic [MASK_W-1:0] done_mask;
      logic [JOB_W-1:0]  job_slot;
      logic              service_sel;
      logic [1:0]        outcome;
   } req_payload_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [JOB_W-1:0]    picked_job;
      logic                picked_service;
      logic                mark_done;
      logic [TIME_W-1:0]   delay_applied;
      logic [PEND_W-1:0]   pending_jobs;
      logic [CNT_W-1:0]    ok_count;
      logic [CNT_W-1:0]    failed_count;
      logic [CNT_W-1:0]    skipped_count;
   } rsp_payload_type;

   // operands for the shared adder/subtractor
   typedef struct packed {
      logic [TIME_W-1:0] a;
      logic [TIME_W-1:0] b;
      logic              sub;
   } alu_req_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
   endfunction

   // 0 services -> none active, 3 acts as 2
   function automatic logic [MASK_W-1:0] active_mask(input logic [1:0] n);
      logic [MASK_W-1:0] m;
      unique case (n)
         2'd0:    m = 2'b00;
         2'd1:    m = 2'b01;
         default: m = 2'b11;
      endcase
      return m;
   endfunction

endpackage

/* src/rsb_chan_if.sv */
// Interface: valid/ready channel carrying one payload per transaction.
`timescale 1ns / 1ps
interface rsb_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* src/rsb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rsb_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

/* src/rsb_alu.sv */
// Shared 32-bit adder/subtractor: due checks, backoff cap compare, next-allowed time.
`timescale 1ns / 1ps
module rsb_alu import rsb_pkg::*; (
   input  alu_req_type       req,
   output logic [TIME_W:0]   result
);
   // bit TIME_W is the carry on add, the borrow on subtract
   always_comb begin
      if (req.sub) begin
         result = {1'b0, req.a} - {1'b0, req.b};
      end else begin
         result = {1'b0, req.a} + {1'b0, req.b};
      end
   end
endmodule

/* src/retry_scheduler_with_backoff.sv */
// Top level: job table, per-service backoff state and the sequencer around the shared ALU.
// Usage:
//   req_if (sink) takes one command per transaction: clear, add job, pick the
//   first due job/service pair, or report the outcome of an attempt. rsp_if
//   (source) returns exactly one result per command, in order, from an output
//   register; a command is taken while an earlier result still waits there.
//   csr_wr_en/csr_index/csr_wr_data write the service count and per-service
//   pacing and backoff cap; write only while no command is in flight.
// Sequence (from accept to rsp valid, receiver not stalling): clear, add job and
//   report on a bad slot or inactive service go straight to S_OUT; report on a
//   bit not owed reads and checks the owed mask; success or hard error also sets
//   the next-allowed time; transient failure adds the cap compare before that.
//   pick: two due checks, then a scan with one owed-mask RAM read per slot.
// Flow: req ready is high only while the sequencer is idle, so a command is not
//   taken until the one before it has reached the output register.
// Reset: synchronous, active high; clears the table, counters, backoff and
//   next-allowed times and loads configuration defaults. The owed-mask RAM is
//   not cleared; slots past the job count are never read.
// Stall: a stalled receiver holds the result; the next command can be taken,
//   and its result waits in the sequencer until the output register frees.
`timescale 1ns / 1ps
module retry_scheduler_with_backoff import rsb_pkg::*; #(
   parameter int MAX_JOBS = DEF_MAX_JOBS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [TIME_W-1:0]     csr_wr_data,
   rsb_chan_if.sink              req_if,
   rsb_chan_if.source            rsp_if
);
   localparam int AW    = $clog2(MAX_JOBS);
   localparam int CW    = $clog2(MAX_JOBS + 1);
   localparam int CMP_W = (CW > JOB_W) ? CW : JOB_W;

   state_type            state_ff, state_in;
   req_payload_type      req_ff, req_in;

   logic [1:0]           svc_use_ff;
   logic [TIME_W-1:0]    min_int_ff [NUM_SVC];
   logic [TIME_W-1:0]    max_bo_ff  [NUM_SVC];

   logic [CW-1:0]        job_count_ff, job_count_in;
   logic [CW-1:0]        pending_ff, pending_in;
   logic [CNT_W-1:0]     ok_ff, ok_in;
   logic [CNT_W-1:0]     fail_ff, fail_in;
   logic [CNT_W-1:0]     skip_ff, skip_in;
   logic [TIME_W-1:0]    backoff_ff [NUM_SVC];
   logic [TIME_W-1:0]    backoff_in [NUM_SVC];
   logic [TIME_W-1:0]    next_ff [NUM_SVC];
   logic [TIME_W-1:0]    next_in [NUM_SVC];

   logic [CW-1:0]        idx_ff, idx_in;
   logic                 pend_ff, pend_in;
   logic [AW-1:0]        pend_idx_ff, pend_idx_in;
   logic [MASK_W-1:0]    due_ff, due_in;

   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [JOB_W-1:0]     pj_ff, pj_in;
   logic                 ps_ff, ps_in;
   logic                 mark_ff, mark_in;
   logic [TIME_W-1:0]    delay_ff, delay_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_data_ff, rsp_data_in;

   logic                 ram_we, ram_re;
   logic [AW-1:0]        ram_waddr, ram_raddr;
   logic [MASK_W-1:0]    ram_wdata, ram_rdata;

   alu_req_type          alu_req;
   logic [TIME_W:0]      alu_res;

   logic                 req_accept;
   logic [MASK_W-1:0]    amask;

   assign amask          = active_mask(svc_use_ff);
   assign req_if.ready   = (state_ff == S_IDLE);
   assign req_accept     = req_if.valid && req_if.ready;
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

   rsb_ram #(
      .WIDTH (MASK_W),
      .DEPTH (MAX_JOBS)
   ) u_owed_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   rsb_alu u_alu (
      .req    (alu_req),
      .result (alu_res)
   );

   always_comb begin
      logic [MASK_W-1:0] owed;
      logic [MASK_W-1:0] new_mask;
      logic [MASK_W-1:0] hit;
      logic              sel;
      logic              bad;

      state_in     = state_ff;
      req_in       = req_ff;
      job_count_in = job_count_ff;
      pending_in   = pending_ff;
      ok_in        = ok_ff;
      fail_in      = fail_ff;
      skip_in      = skip_ff;
      backoff_in   = backoff_ff;
      next_in      = next_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      due_in       = due_ff;
      status_in    = status_ff;
      pj_in        = pj_ff;
      ps_in        = ps_ff;
      mark_in      = mark_ff;
      delay_in     = delay_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;

      ram_we    = 1'b0;
      ram_waddr = job_count_ff[AW-1:0];
      ram_wdata = '0;
      ram_re    = 1'b0;
      ram_raddr = idx_ff[AW-1:0];
      alu_req   = '{a: req_ff.now_ms, b: delay_ff, sub: 1'b0};

      sel      = req_ff.service_sel;
      owed     = ~req_if.payload.done_mask & amask;
      new_mask = ram_rdata & ~(MASK_W'(1) << sel);
      hit      = ram_rdata & due_ff;
      bad      = (CMP_W'(req_if.payload.job_slot) >= CMP_W'(job_count_ff)) ||
                 !amask[req_if.payload.service_sel];

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               req_in    = req_if.payload;
               status_in = ST_DONE;
               pj_in     = '0;
               ps_in     = 1'b0;
               mark_in   = 1'b0;
               delay_in  = '0;
               unique case (req_if.payload.op)
                  OP_CLEAR: begin
                     job_count_in = '0;
                     pending_in   = '0;
                     ok_in        = '0;
                     fail_in      = '0;
                     skip_in      = '0;
                     state_in     = S_OUT;
                  end
                  OP_ADD: begin
                     if (owed == '0) begin
                        skip_in   = sat_inc(skip_ff);
                        status_in = ST_SKIPPED;
                     end else if (job_count_ff >= CW'(MAX_JOBS)) begin
                        status_in = ST_FULL;
                     end else begin
                        ram_we       = 1'b1;
                        ram_wdata    = owed;
                        pj_in        = JOB_W'(job_count_ff[AW-1:0]);
                        job_count_in = job_count_ff + CW'(1);
                        pending_in   = pending_ff + CW'(1);
                     end
                     state_in = S_OUT;
                  end
                  OP_PICK: begin
                     idx_in   = '0;
                     pend_in  = 1'b0;
                     state_in = S_DUE0;
                  end
                  OP_REPORT: begin
                     pj_in = req_if.payload.job_slot;
                     ps_in = req_if.payload.service_sel;
                     if (bad) begin
                        status_in = ST_NOT_OWED;
                        state_in  = S_OUT;
                     end else begin
                        state_in = S_RPT_RD;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_DUE0: begin
            // wrap-safe due test: sign of now - next_allowed
            alu_req   = '{a: req_ff.now_ms, b: next_ff[0], sub: 1'b1};
            due_in[0] = !alu_res[TIME_W-1] && amask[0];
            state_in  = S_DUE1;
         end
         S_DUE1: begin
            alu_req   = '{a: req_ff.now_ms, b: next_ff[1], sub: 1'b1};
            due_in[1] = !alu_res[TIME_W-1] && amask[1];
            state_in  = S_SCAN;
         end
         S_SCAN: begin
            // read slot idx while checking the slot read last cycle
            if (pend_ff && (hit != '0)) begin
               pj_in     = JOB_W'(pend_idx_ff);
               ps_in     = !hit[0];
               status_in = ST_DONE;
               state_in  = S_OUT;
            end else if (idx_ff < job_count_ff) begin
               ram_re      = 1'b1;
               idx_in      = idx_ff + CW'(1);
               pend_in     = 1'b1;
               pend_idx_in = idx_ff[AW-1:0];
            end else if (!pend_ff) begin
               status_in = ST_NONE_DUE;
               state_in  = S_OUT;
            end else begin
               pend_in = 1'b0;
            end
         end
         S_RPT_RD: begin
            ram_re    = 1'b1;
            ram_raddr = AW'(req_ff.job_slot);
            state_in  = S_RPT_CHK;
         end
         S_RPT_CHK: begin
            if (!ram_rdata[sel]) begin
               status_in = ST_NOT_OWED;
               state_in  = S_OUT;
            end else begin
               case (req_ff.outcome)
                  OUTC_SUCCESS: begin
                     ram_we          = 1'b1;
                     ram_waddr       = AW'(req_ff.job_slot);
                     ram_wdata       = new_mask;
                     backoff_in[sel] = '0;
                     delay_in        = min_int_ff[sel];
                     ok_in           = sat_inc(ok_ff);
                     mark_in         = 1'b1;
                     if (new_mask == '0) begin
                        pending_in = pending_ff - CW'(1);
                     end
                     state_in = S_NEXT;
                  end
                  OUTC_TRANSIENT: begin
                     if (backoff_ff[sel] != '0) begin
                        delay_in = backoff_ff[sel][TIME_W-1] ? '1 : (backoff_ff[sel] << 1);
                     end else if (min_int_ff[sel] != '0) begin
                        delay_in = min_int_ff[sel];
                     end else begin
                        delay_in = FIRST_BACKOFF_MS;
                     end
                     fail_in  = sat_inc(fail_ff);
                     state_in = S_CAP;
                  end
                  default: begin
                     // hard error, outcome 3 included
                     ram_we    = 1'b1;
                     ram_waddr = AW'(req_ff.job_slot);
                     ram_wdata = new_mask;
                     delay_in  = min_int_ff[sel];
                     fail_in   = sat_inc(fail_ff);
                     if (new_mask == '0) begin
                        pending_in = pending_ff - CW'(1);
                     end
                     state_in = S_NEXT;
                  end
               endcase
            end
         end
         S_CAP: begin
            // borrow on max - candidate means candidate exceeds the cap
            alu_req = '{a: max_bo_ff[sel], b: delay_ff, sub: 1'b1};
            if (alu_res[TIME_W]) begin
               delay_in        = max_bo_ff[sel];
               backoff_in[sel] = max_bo_ff[sel];
            end else begin
               backoff_in[sel] = delay_ff;
            end
            state_in = S_NEXT;
         end
         S_NEXT: begin
            alu_req      = '{a: req_ff.now_ms, b: delay_ff, sub: 1'b0};
            next_in[sel] = alu_res[TIME_W-1:0];
            status_in    = ST_DONE;
            state_in     = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.status          = status_ff;
               rsp_data_in.picked_job      = pj_ff;
               rsp_data_in.picked_service  = ps_ff;
               rsp_data_in.mark_done       = mark_ff;
               rsp_data_in.delay_applied   = delay_ff;
               rsp_data_in.pending_jobs    = PEND_W'(pending_ff);
               rsp_data_in.ok_count        = ok_ff;
               rsp_data_in.failed_count    = fail_ff;
               rsp_data_in.skipped_count   = skip_ff;
               state_in                    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_count_ff <= '0;
         pending_ff   <= '0;
         ok_ff        <= '0;
         fail_ff      <= '0;
         skip_ff      <= '0;
         backoff_ff   <= '{default: '0};
         next_ff      <= '{default: '0};
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_count_ff <= job_count_in;
         pending_ff   <= pending_in;
         ok_ff        <= ok_in;
         fail_ff      <= fail_in;
         skip_ff      <= skip_in;
         backoff_ff   <= backoff_in;
         next_ff      <= next_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      pend_idx_ff <= pend_idx_in;
      due_ff      <= due_in;
      status_ff   <= status_in;
      pj_ff       <= pj_in;
      ps_ff       <= ps_in;
      mark_ff     <= mark_in;
      delay_ff    <= delay_in;
      rsp_data_ff <= rsp_data_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         svc_use_ff <= 2'd2;
         min_int_ff <= '{default: '0};
         max_bo_ff  <= '{default: DEF_MAX_BACKOFF};
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SERVICES:   svc_use_ff    <= csr_wr_data[1:0];
            CSR_SVC0_MIN:   min_int_ff[0] <= csr_wr_data;
            CSR_SVC0_MAXBO: max_bo_ff[0]  <= csr_wr_data;
            CSR_SVC1_MIN:   min_int_ff[1] <= csr_wr_data;
            CSR_SVC1_MAXBO: max_bo_ff[1]  <= csr_wr_data;
            default: ;
         endcase
      end
   end

   a_jobs_bounded: assert property (@(posedge clock) disable iff (reset)
      job_count_ff <= CW'(MAX_JOBS))
      else $error("job count exceeds table size");

   a_pending_le_jobs: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= job_count_ff)
      else $error("pending jobs exceed job count");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_if.payload.op == OP_CLEAR) |=> (job_count_ff == '0) &&
      (pending_ff == '0))
      else $error("clear did not empty the table");

   a_out_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) && (!rsp_valid_ff || rsp_if.ready) |=>
      rsp_valid_ff && (state_ff == S_IDLE))
      else $error("result not loaded into output register");

   a_scan_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) && pend_ff |-> (CW'(pend_idx_ff) < job_count_ff))
      else $error("scan checked a slot past the job count");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the retry scheduler: directed table, then random phased traffic.
`timescale 1ns / 1ps
module tb_top;
   import rsb_pkg::*;

   localparam int ITEM_TARGET    = 1150;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int END_WAIT       = 80;
   localparam logic [1:0] OUTC_HARD_ALT = 2'd3;   // undefined outcome code, acts as hard error

   typedef struct {
      req_payload_type req;
      bit              fixed;
      rsp_payload_type want;
   } vec_row_type;

   logic clock;
   logic reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [TIME_W-1:0]    csr_wr_data;

   rsb_chan_if #(.payload_type(req_payload_type)) req_ch ();
   rsb_chan_if #(.payload_type(rsp_payload_type)) rsp_ch ();

   retry_scheduler_with_backoff dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch)
   );

   // scheduler state as the testbench sees it
   logic [1:0]        svc_count;
   logic [TIME_W-1:0] min_gap [NUM_SVC];
   logic [TIME_W-1:0] bo_cap [NUM_SVC];
   logic [TIME_W-1:0] backoff_cur [NUM_SVC];
   logic [TIME_W-1:0] next_ok [NUM_SVC];
   logic [MASK_W-1:0] owed_tbl [DEF_MAX_JOBS];
   int                job_total;
   int                pend_total;
   logic [CNT_W-1:0]  ok_total;
   logic [CNT_W-1:0]  fail_total;
   logic [CNT_W-1:0]  skip_total;

   rsp_payload_type sched_rsp_q [$];
   rsp_payload_type last_rsp;
   vec_row_type     directed_rows [$];

   int  err_count;
   int  items_sent;
   int  settings_used;
   int  op_seen [4];
   int  status_seen [8];
   int  quiet_cycles;
   bit  no_idle;
   bit  long_hold;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [CNT_W-1:0] sat16(input logic [CNT_W-1:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic int svc_active();
      return (svc_count == 2'd0) ? 0 : (svc_count == 2'd1) ? 1 : 2;
   endfunction

   function automatic logic [MASK_W-1:0] svc_mask();
      return (svc_count == 2'd0) ? 2'b00 : (svc_count == 2'd1) ? 2'b01 : 2'b11;
   endfunction

   // one command against the shadow state; returns the result it should produce
   function automatic rsp_payload_type schedule_step(input req_payload_type r);
      rsp_payload_type   o;
      logic [MASK_W-1:0] owed;
      logic [TIME_W-1:0] b;
      logic [TIME_W-1:0] diff;
      int                n_act;
      int                sel;
      bit                found;
      o = '0;
      n_act = svc_active();
      found = 1'b0;
      case (r.op)
         OP_CLEAR: begin
            job_total  = 0;
            pend_total = 0;
            ok_total   = '0;
            fail_total = '0;
            skip_total = '0;
         end
         OP_ADD: begin
            owed = ~r.done_mask & svc_mask();
            if (owed == '0) begin
               skip_total = sat16(skip_total);
               o.status = ST_SKIPPED;
            end else if (job_total >= DEF_MAX_JOBS) begin
               o.status = ST_FULL;
            end else begin
               owed_tbl[job_total] = owed;
               o.picked_job = JOB_W'(job_total);
               job_total++;
               pend_total++;
            end
         end
         OP_PICK: begin
            for (int i = 0; i < job_total && !found; i++) begin
               for (int s = 0; s < n_act && !found; s++) begin
                  diff = r.now_ms - next_ok[s];
                  // due when now - next_allowed is not negative as a signed value
                  if (owed_tbl[i][s] && !diff[TIME_W-1]) begin
                     found = 1'b1;
                     o.picked_job = JOB_W'(i);
                     o.picked_service = 1'(s);
                  end
               end
            end
            o.status = found ? ST_DONE : ST_NONE_DUE;
         end
         default: begin
            o.picked_job = r.job_slot;
            o.picked_service = r.service_sel;
            sel = r.service_sel;
            if (r.job_slot >= job_total || sel >= n_act || !owed_tbl[r.job_slot][sel]) begin
               o.status = ST_NOT_OWED;
            end else begin
               case (r.outcome)
                  OUTC_SUCCESS: begin
                     owed_tbl[r.job_slot][sel] = 1'b0;
                     backoff_cur[sel] = '0;
                     b = min_gap[sel];
                     ok_total = sat16(ok_total);
                     o.mark_done = 1'b1;
                  end
                  OUTC_TRANSIENT: begin
                     if (backoff_cur[sel] != '0)
                        b = (backoff_cur[sel] > 32'h7FFF_FFFF) ? '1 : backoff_cur[sel] << 1;
                     else
                        b = (min_gap[sel] != '0) ? min_gap[sel] : FIRST_BACKOFF_MS;
                     if (b > bo_cap[sel])
                        b = bo_cap[sel];
                     backoff_cur[sel] = b;
                     fail_total = sat16(fail_total);
                  end
                  default: begin
                     owed_tbl[r.job_slot][sel] = 1'b0;
                     b = min_gap[sel];
                     fail_total = sat16(fail_total);
                  end
               endcase
               next_ok[sel] = r.now_ms + b;
               o.delay_applied = b;
               pend_total = 0;
               for (int i = 0; i < job_total; i++)
                  if (owed_tbl[i] != '0)
                     pend_total++;
            end
         end
      endcase
      o.pending_jobs  = PEND_W'(pend_total);
      o.ok_count      = ok_total;
      o.failed_count  = fail_total;
      o.skipped_count = skip_total;
      return o;
   endfunction

   function automatic req_payload_type mk_req(input op_type op, input logic [TIME_W-1:0] t,
                                              input logic [1:0] dm, input logic [JOB_W-1:0] slot,
                                              input logic sel, input logic [1:0] oc);
      req_payload_type q;
      q.op = op;
      q.now_ms = t;
      q.done_mask = dm;
      q.job_slot = slot;
      q.service_sel = sel;
      q.outcome = oc;
      return q;
   endfunction

   function automatic rsp_payload_type mk_rsp(input status_type st, input logic [JOB_W-1:0] pj,
                                              input logic ps, input logic mk,
                                              input logic [TIME_W-1:0] dly,
                                              input logic [PEND_W-1:0] pend,
                                              input logic [CNT_W-1:0] okc,
                                              input logic [CNT_W-1:0] fc,
                                              input logic [CNT_W-1:0] sc);
      rsp_payload_type o;
      o.status = st;
      o.picked_job = pj;
      o.picked_service = ps;
      o.mark_done = mk;
      o.delay_applied = dly;
      o.pending_jobs = pend;
      o.ok_count = okc;
      o.failed_count = fc;
      o.skipped_count = sc;
      return o;
   endfunction

   // append one row to the directed table
   function automatic void queue_row(input req_payload_type r, input bit fixed,
                                     input rsp_payload_type w);
      vec_row_type row;
      row.req = r;
      row.fixed = fixed;
      row.want = w;
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   function automatic req_payload_type rand_req();
      req_payload_type q;
      q = mk_req(op_type'($urandom_range(0, 3)), $urandom, 2'($urandom_range(0, 3)),
                 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
      return q;
   endfunction

   function automatic logic [1:0] rand_outcome();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return OUTC_SUCCESS;
      else if (r < 85)
         return OUTC_TRANSIENT;
      else if (r < 96)
         return OUTC_HARD;
      return OUTC_HARD_ALT;
   endfunction

   // mostly short gaps, some medium, a few long
   function automatic int rand_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [TIME_W-1:0] next_time(input logic [TIME_W-1:0] t);
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return t + $urandom_range(0, 2500);
      else if (r < 90)
         return t + $urandom_range(0, 200000);
      else if (r < 98)
         return $urandom;
      return t - $urandom_range(0, 1000);
   endfunction

   // random job/service pair that is still owed to an active service
   function automatic bit find_owed(output int slot, output int sel);
      int                start;
      int                i;
      logic [MASK_W-1:0] m;
      slot = 0;
      sel = 0;
      if (job_total == 0)
         return 1'b0;
      start = $urandom_range(0, job_total - 1);
      for (int k = 0; k < job_total; k++) begin
         i = (start + k) % job_total;
         m = owed_tbl[i] & svc_mask();
         if (m != '0) begin
            slot = i;
            sel = (m == 2'b11) ? $urandom_range(0, 1) : (m == 2'b10);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   task automatic write_reg(input csr_index_type idx, input logic [TIME_W-1:0] d);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= d;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_SERVICES:   svc_count = d[1:0];
         CSR_SVC0_MIN:   min_gap[0] = d;
         CSR_SVC0_MAXBO: bo_cap[0] = d;
         CSR_SVC1_MIN:   min_gap[1] = d;
         CSR_SVC1_MAXBO: bo_cap[1] = d;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // offer one command, record its predicted result once it is taken
   task automatic send(input req_payload_type r, input bit fixed, input rsp_payload_type lit);
      rsp_payload_type p;
      int              gap;
      req_ch.valid   <= 1'b1;
      req_ch.payload <= r;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      p = schedule_step(r);
      sched_rsp_q.insert(sched_rsp_q.size(), fixed ? lit : p);
      last_rsp = p;
      items_sent++;
      op_seen[r.op]++;
      status_seen[p.status]++;
      gap = no_idle ? 0 : rand_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      if (req_ch.valid)
         req_ch.valid <= 1'b0;
      while (sched_rsp_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [TIME_W-1:0] pick_interval(input int k);
      case (k)
         0:       return '1;
         1:       return '0;
         2:       return $urandom_range(1, 3000);
         3:       return $urandom;
         4:       return '0;
         default: return $urandom_range(1, 3000);
      endcase
   endfunction

   function automatic logic [TIME_W-1:0] pick_cap(input int k);
      case (k)
         0:       return '1;
         1:       return '0;
         2:       return $urandom_range(1000, 200000);
         3:       return $urandom;
         4:       return DEF_MAX_BACKOFF;
         default: return $urandom_range(0, 5000);
      endcase
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t ERROR %s: expected 0x%0h, actual 0x%0h", $time, name, want, got);
         err_count++;
      end
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (sched_rsp_q.size() == 0) begin
            $display("%0t ERROR unexpected result: expected none, actual status %0d job %0d",
                     $time, rsp_ch.payload.status, rsp_ch.payload.picked_job);
            err_count++;
         end else begin
            want = sched_rsp_q.pop_front();
            check_field("status", want.status, rsp_ch.payload.status);
            check_field("picked_job", want.picked_job, rsp_ch.payload.picked_job);
            check_field("picked_service", want.picked_service, rsp_ch.payload.picked_service);
            check_field("mark_done", want.mark_done, rsp_ch.payload.mark_done);
            check_field("delay_applied", want.delay_applied, rsp_ch.payload.delay_applied);
            check_field("pending_jobs", want.pending_jobs, rsp_ch.payload.pending_jobs);
            check_field("ok_count", want.ok_count, rsp_ch.payload.ok_count);
            check_field("failed_count", want.failed_count, rsp_ch.payload.failed_count);
            check_field("skipped_count", want.skipped_count, rsp_ch.payload.skipped_count);
         end
      end
   end

   // watchdog: no transaction on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || csr_wr_en)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t TIMEOUT: no transaction for %0d cycles, %0d results outstanding",
                  $time, quiet_cycles, sched_rsp_q.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // result side backpressure, with one long hold on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            long_hold = 1'b0;
            stall_left = HOLD_CYCLES;
         end else if (stall_left == 0 && !no_idle) begin
            stall_left = rand_gap();
         end
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      req_payload_type q;
      logic [TIME_W-1:0] tnow;
      int phase;
      int r;
      int n;
      int slot;
      int sel;
      int k0;
      int k1;
      logic [1:0] svc_sel_cfg;

      reset          <= 1'b1;
      csr_wr_en      <= 1'b0;
      csr_index      <= CSR_SERVICES;
      csr_wr_data    <= '0;
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
      svc_count = 2'd2;
      for (int s = 0; s < NUM_SVC; s++) begin
         min_gap[s] = '0;
         bo_cap[s] = DEF_MAX_BACKOFF;
         backoff_cur[s] = '0;
         next_ok[s] = '0;
      end
      foreach (owed_tbl[i])
         owed_tbl[i] = '0;
      job_total = 0;
      pend_total = 0;
      ok_total = '0;
      fail_total = '0;
      skip_total = '0;
      err_count = 0;
      items_sent = 0;
      settings_used = 1;
      quiet_cycles = 0;
      no_idle = 1'b0;
      long_hold = 1'b0;
      last_rsp = '0;
      foreach (op_seen[i])
         op_seen[i] = 0;
      foreach (status_seen[i])
         status_seen[i] = 0;

      // directed table, default configuration
      queue_row(mk_req(OP_PICK, 0, 0, 0, 0, 0), 1,
                mk_rsp(ST_NONE_DUE, 0, 0, 0, 0, 0, 0, 0, 0));
      queue_row(mk_req(OP_REPORT, 0, 0, 0, 1, OUTC_SUCCESS), 1,
                mk_rsp(ST_NOT_OWED, 0, 1, 0, 0, 0, 0, 0, 0));
      queue_row(mk_req(OP_ADD, 0, 2'b11, 0, 0, 0), 1,
                mk_rsp(ST_SKIPPED, 0, 0, 0, 0, 0, 0, 0, 1));
      queue_row(mk_req(OP_ADD, 0, 2'b00, 0, 0, 0), 1,
                mk_rsp(ST_DONE, 0, 0, 0, 0, 1, 0, 0, 1));
      queue_row(mk_req(OP_ADD, 0, 2'b01, 0, 0, 0), 0, '0);
      queue_row(mk_req(OP_ADD, 0, 2'b10, 0, 0, 0), 0, '0);
      queue_row(mk_req(OP_PICK, 0, 0, 0, 0, 0), 0, '0);
      queue_row(mk_req(OP_REPORT, 100, 0, 0, 0, OUTC_SUCCESS), 0, '0);
      queue_row(mk_req(OP_REPORT, 100, 0, 0, 1, OUTC_TRANSIENT), 0, '0);
      queue_row(mk_req(OP_REPORT, 200, 0, 0, 1, OUTC_TRANSIENT), 0, '0);
      queue_row(mk_req(OP_PICK, 1000, 0, 0, 0, 0), 0, '0);
      queue_row(mk_req(OP_REPORT, 1000, 0, 1, 1, OUTC_HARD), 0, '0);
      queue_row(mk_req(OP_REPORT, '1, 0, 0, 1, OUTC_HARD_ALT), 0, '0);
      queue_row(mk_req(OP_REPORT, '1, 2'b11, 63, 1, OUTC_SUCCESS), 1,
                mk_rsp(ST_NOT_OWED, 63, 1, 0, 0, 1, 1, 4, 1));
      // signed compare just either side of half the time range
      queue_row(mk_req(OP_PICK, 32'h7FFF_FFFF, 0, 0, 0, 0), 0, '0);
      queue_row(mk_req(OP_PICK, 32'h8000_0064, 0, 0, 0, 0), 0, '0);
      // first transient backoff wraps next-allowed past zero
      queue_row(mk_req(OP_REPORT, '1, 0, 2, 0, OUTC_TRANSIENT), 0, '0);
      queue_row(mk_req(OP_PICK, 500, 0, 0, 0, 0), 0, '0);
      queue_row(mk_req(OP_PICK, 999, 0, 0, 0, 0), 0, '0);
      queue_row(mk_req(OP_REPORT, 999, 0, 2, 1, OUTC_SUCCESS), 0, '0);
      queue_row(mk_req(OP_CLEAR, 0, 0, 0, 0, 0), 1,
                mk_rsp(ST_DONE, 0, 0, 0, 0, 0, 0, 0, 0));
      queue_row(mk_req(OP_PICK, 0, 0, 0, 0, 0), 1,
                mk_rsp(ST_NONE_DUE, 0, 0, 0, 0, 0, 0, 0, 0));
      queue_row(mk_req(OP_ADD, '1, 2'b00, 63, 1, OUTC_HARD_ALT), 0, '0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].want);

      // random phases, each under its own setting
      tnow = 0;
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         drain();
         if (phase < 4) begin
            case (phase)
               0:       svc_sel_cfg = 2'd2;
               1:       svc_sel_cfg = 2'd1;
               2:       svc_sel_cfg = 2'd3;
               default: svc_sel_cfg = 2'd0;
            endcase
            k0 = phase;
            k1 = (phase + 3) % 6;
         end else begin
            r = $urandom_range(0, 99);
            svc_sel_cfg = (r < 70) ? 2'd2 : (r < 85) ? 2'd1 : (r < 93) ? 2'd3 : 2'd0;
            k0 = $urandom_range(0, 5);
            k1 = $urandom_range(0, 5);
         end
         write_reg(CSR_SERVICES, TIME_W'(svc_sel_cfg));
         write_reg(CSR_SVC0_MIN, pick_interval(k0));
         write_reg(CSR_SVC0_MAXBO, pick_cap(k0));
         write_reg(CSR_SVC1_MIN, pick_interval(k1));
         write_reg(CSR_SVC1_MAXBO, pick_cap(k1));
         settings_used++;
         no_idle = ($urandom_range(0, 5) == 0) && phase != 2;
         if ($urandom_range(0, 3) == 0)
            tnow = 32'hFFFF_FFFF - $urandom_range(0, 20000);
         // fill the input side while the result side holds off
         if (phase == 2)
            long_hold = 1'b1;
         if (phase == 0 || $urandom_range(0, 2) != 0)
            send(mk_req(OP_CLEAR, tnow, 0, 0, 0, 0), 0, '0);

         if (phase % 3 == 0) begin
            n = $urandom_range(80, 95);
            repeat (n) begin
               if (items_sent >= ITEM_TARGET)
                  break;
               q = rand_req();
               q.op = OP_ADD;
               q.now_ms = tnow;
               if ($urandom_range(0, 99) < 85)
                  q.done_mask = 2'($urandom_range(0, 2));
               send(q, 0, '0);
            end
         end

         n = $urandom_range(40, 70);
         repeat (n) begin
            if (items_sent >= ITEM_TARGET)
               break;
            r = $urandom_range(0, 99);
            tnow = next_time(tnow);
            q = rand_req();
            q.now_ms = tnow;
            if (r < 45) begin
               q.op = OP_PICK;
               send(q, 0, '0);
               if (last_rsp.status == ST_DONE && $urandom_range(0, 9) != 0) begin
                  q = rand_req();
                  q.op = OP_REPORT;
                  q.now_ms = tnow + $urandom_range(0, 50);
                  q.job_slot = last_rsp.picked_job;
                  q.service_sel = last_rsp.picked_service;
                  q.outcome = rand_outcome();
                  send(q, 0, '0);
               end
            end else if (r < 60) begin
               q.op = OP_ADD;
               send(q, 0, '0);
            end else if (r < 75) begin
               if (find_owed(slot, sel)) begin
                  q.op = OP_REPORT;
                  q.job_slot = 6'(slot);
                  q.service_sel = 1'(sel);
                  q.outcome = rand_outcome();
               end else begin
                  q.op = OP_ADD;
               end
               send(q, 0, '0);
            end else if (r < 92) begin
               q.op = OP_REPORT;
               send(q, 0, '0);
            end else if (r < 97) begin
               q.op = OP_PICK;
               q.now_ms = $urandom;
               send(q, 0, '0);
            end else begin
               q.op = OP_CLEAR;
               send(q, 0, '0);
            end
         end
         phase++;
      end

      drain();
      repeat (END_WAIT) @(posedge clock);
      $display("Run: %0d transactions under %0d settings (%0d clear, %0d add, %0d pick, %0d report)",
               items_sent, settings_used, op_seen[OP_CLEAR], op_seen[OP_ADD],
               op_seen[OP_PICK], op_seen[OP_REPORT]);
      $display("Statuses: %0d done, %0d nothing due, %0d skipped, %0d full, %0d not owed; %0d errors",
               status_seen[ST_DONE], status_seen[ST_NONE_DUE], status_seen[ST_SKIPPED],
               status_seen[ST_FULL], status_seen[ST_NOT_OWED], err_count);
      if (err_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
